@@ hw/rtl/smel_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smel_pkg: shared types and constants for the sorted max extent list
// Action and status codes, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package smel_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int EXTENT_W        = 16;
    localparam int COUNT_W         = 9;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_SAME   = 2'd0,
        ST_TOP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CHK,
        S_INS_TOP,
        S_REM_RD,
        S_REM_CHK,
        S_DONE
    } t_state;

endpackage

@@ hw/rtl/sorted_max_extent_list_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_max_extent_list_core: descending sorted multiset with max tracking
// Holds up to MAX_ENTRIES extents in one memory, keeps the largest to hand.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one item; busy stays high until
// the single result has been shown on o_done for one cycle, which cannot be
// held off. A clear, an unused action, an insert into a full or empty list
// and a remove from an empty list go straight from S_IDLE to S_DONE. An
// insert reads an entry in S_INS_RD and shifts it down in S_INS_CHK,
// walking up from the bottom to its slot, with S_INS_TOP for the top slot;
// a remove reads and compares every entry in S_REM_RD and S_REM_CHK. The
// single read port gives each entry a read and a compare-and-write state.
module sorted_max_extent_list_core
    import smel_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_action,
    input  logic [EXTENT_W-1:0] i_extent,
    output logic                o_done,
    output logic [1:0]          o_status,
    output logic [EXTENT_W-1:0] o_max_extent,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    t_state r_state, n_state;

    logic [EXTENT_W-1:0] r_mem [MAX_ENTRIES];
    logic [EXTENT_W-1:0] r_rdata;
    logic [AW-1:0]       w_raddr;
    logic [AW-1:0]       w_waddr;
    logic [EXTENT_W-1:0] w_wdata;
    logic                w_we;

    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_k, n_k;
    logic [EXTENT_W-1:0] r_max, n_max;
    logic [EXTENT_W-1:0] r_v, n_v;
    logic                r_found, n_found;
    logic                r_pos0, n_pos0;
    t_status             r_status, n_status;

    logic [CW-1:0]       w_km1;
    logic [CW-1:0]       w_kp1;
    logic                w_hit;
    logic                w_last;
    logic [CW+COUNT_W-1:0] w_count_ext;

    assign w_km1  = r_k - CW'(1);
    assign w_kp1  = r_k + CW'(1);
    assign w_hit  = r_found || (r_rdata == r_v);
    assign w_last = (w_kp1 == r_count);

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_max   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_v      <= n_v;
        r_found  <= n_found;
        r_pos0   <= n_pos0;
        r_status <= n_status;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    unique case (t_action'(i_action))
                        ACT_INSERT: begin
                            if ((r_count >= CW'(MAX_ENTRIES)) || (r_count == '0)) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_INS_RD;
                            end
                        end
                        ACT_REMOVE: begin
                            n_state = (r_count == '0) ? S_DONE : S_REM_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD:  n_state = S_INS_CHK;
            S_INS_CHK: begin
                if (r_rdata <= r_v) begin
                    n_state = (r_k == CW'(1)) ? S_INS_TOP : S_INS_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS_TOP: n_state = S_DONE;
            S_REM_RD:  n_state = S_REM_CHK;
            S_REM_CHK: n_state = w_last ? S_DONE : S_REM_RD;
            S_DONE:    n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count  = r_count;
        n_k      = r_k;
        n_max    = r_max;
        n_v      = r_v;
        n_found  = r_found;
        n_pos0   = r_pos0;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_k[AW-1:0];
        w_wdata  = r_v;
        w_raddr  = r_k[AW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_v     = i_extent;
                    n_found = 1'b0;
                    n_pos0  = 1'b0;
                    unique case (t_action'(i_action))
                        ACT_INSERT: begin
                            if (r_count >= CW'(MAX_ENTRIES)) begin
                                n_status = ST_FULL;
                            end else if (r_count == '0) begin
                                w_we     = 1'b1;
                                w_waddr  = '0;
                                w_wdata  = i_extent;
                                n_max    = i_extent;
                                n_count  = CW'(1);
                                n_status = ST_TOP;
                            end else begin
                                n_k = r_count;
                            end
                        end
                        ACT_REMOVE: begin
                            n_k = '0;
                            if (r_count == '0) begin
                                n_status = ST_ABSENT;
                            end
                        end
                        ACT_CLEAR: begin
                            n_status = (r_count != '0) ? ST_TOP : ST_SAME;
                            n_count  = '0;
                            n_max    = '0;
                        end
                        default: n_status = ST_SAME;
                    endcase
                end
            end
            S_INS_RD: begin
                w_raddr = w_km1[AW-1:0];
            end
            S_INS_CHK: begin
                w_we    = 1'b1;
                w_waddr = r_k[AW-1:0];
                if (r_rdata <= r_v) begin
                    w_wdata = r_rdata;
                    n_k     = w_km1;
                end else begin
                    w_wdata  = r_v;
                    n_count  = r_count + CW'(1);
                    n_status = ST_SAME;
                end
            end
            S_INS_TOP: begin
                w_we     = 1'b1;
                w_waddr  = '0;
                w_wdata  = r_v;
                n_max    = r_v;
                n_count  = r_count + CW'(1);
                n_status = ST_TOP;
            end
            S_REM_RD: begin
                w_raddr = r_k[AW-1:0];
            end
            S_REM_CHK: begin
                if (r_found) begin
                    w_we    = 1'b1;
                    w_waddr = w_km1[AW-1:0];
                    w_wdata = r_rdata;
                    if (r_k == CW'(1)) begin
                        n_max = r_rdata;
                    end
                end else if (r_rdata == r_v) begin
                    n_found = 1'b1;
                    n_pos0  = (r_k == '0);
                end
                if (w_last) begin
                    if (!w_hit) begin
                        n_status = ST_ABSENT;
                    end else begin
                        n_count  = r_count - CW'(1);
                        n_status = (r_found ? r_pos0 : (r_k == '0)) ? ST_TOP : ST_SAME;
                        if (r_count == CW'(1)) begin
                            n_max = '0;
                        end
                    end
                end else begin
                    n_k = w_kp1;
                end
            end
            S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    assign w_count_ext   = (CW + COUNT_W)'(r_count);
    assign busy          = (r_state != S_IDLE);
    assign o_done        = (r_state == S_DONE);
    assign o_status      = r_status;
    assign o_max_extent  = r_max;
    assign o_entry_count = w_count_ext[COUNT_W-1:0];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ENTRIES))
        else $error("entry count beyond capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("busy held after result");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_status == ST_FULL) |-> (r_count == CW'(MAX_ENTRIES)))
        else $error("full reported on a list with room");

    a_empty_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (r_count == '0) |-> (r_max == '0))
        else $error("nonzero maximum on an empty list");

endmodule
